/* sv/wdw_pkg.sv */
// shared constants, entry and code types for the weighted draw block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package wdw_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int ID_BITS     = 16;

   localparam int IDX_W   = $clog2(MAX_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int W_BITS  = 16;
   localparam int TOTAL_W = W_BITS + IDX_W;
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = TOTAL_W + FRAC_W;

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic [W_BITS-1:0]  weight;
   } entry_type;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_DRAW  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE  = 3'd0,
      ST_DRAWN = 3'd1,
      ST_EMPTY = 3'd2,
      ST_FULL  = 3'd3,
      ST_ZERO  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_SCAN,
      S_SUM_SCAN,
      S_SCALE,
      S_PICK_SCAN,
      S_RESP
   } state_type;

endpackage

/* sv/wdw_cell.sv */
// one cell of the candidate chain: holds an id and weight, passes it on when shifted
// depends on wdw_pkg
`timescale 1ns / 1ps

module wdw_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  wdw_pkg::entry_type   d_in,
   output wdw_pkg::entry_type   q
);

   wdw_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= d_in;
      end
   end

   assign q = entry_ff;

endmodule

/* sv/wdw_chain.sv */
// circular row of candidate cells, head at cell 0, refilled at the tail
// depends on wdw_pkg and wdw_cell
`timescale 1ns / 1ps

module wdw_chain (
   input  logic                 clock,
   input  logic                 shift,
   input  wdw_pkg::entry_type   tail,
   output wdw_pkg::entry_type   head,
   output wdw_pkg::entry_type   next
);

   wdw_pkg::entry_type q [wdw_pkg::MAX_ENTRIES];

   genvar i;
   generate
      for (i = 0; i < wdw_pkg::MAX_ENTRIES; i++) begin : g_cell
         wdw_pkg::entry_type d;
         if (i == wdw_pkg::MAX_ENTRIES - 1) begin : g_last
            assign d = tail;
         end else begin : g_mid
            assign d = q[i+1];
         end
         wdw_cell u_cell (
            .clock (clock),
            .shift (shift),
            .d_in  (d),
            .q     (q[i])
         );
      end
   endgenerate

   assign head = q[0];
   assign next = q[1];

endmodule

/* sv/weighted_draw_without_replacement.sv */
// Weighted draw without replacement. Candidates sit in a circular chain of MAX_ENTRIES cells
// that rotates one place per cycle while a scan runs; a full rotation brings every entry back
// to its slot, and the controller at the head edits, appends or drops entries as they pass.
// Clear, an unused operation and a zero-weight add go from the accept cycle straight to the
// response. An add runs the accept cycle, one rotation, then the response. A draw runs the
// accept cycle, a rotation to sum the weights, a step to scale the random fraction by the
// total, a second rotation that finds the pick and closes the gap behind it, then the
// response; a draw on an empty table or zero total skips the second rotation. One item is
// worked on at a time; the result word is held in an output register until taken.
// depends on wdw_pkg and wdw_chain
`timescale 1ns / 1ps

module weighted_draw_without_replacement (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_operation,
   input  logic [15:0]  req_item_id,
   input  logic [15:0]  req_weight,
   input  logic [15:0]  req_random_fraction,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [2:0]   rsp_status,
   output logic [15:0]  rsp_drawn_id,
   output logic [6:0]   rsp_entry_count
);

   localparam int IDX_W   = wdw_pkg::IDX_W;
   localparam int CNT_W   = wdw_pkg::CNT_W;
   localparam int TOTAL_W = wdw_pkg::TOTAL_W;
   localparam int PROD_W  = wdw_pkg::PROD_W;
   localparam int W_BITS  = wdw_pkg::W_BITS;
   localparam int ID_BITS = wdw_pkg::ID_BITS;
   localparam int FRAC_W  = wdw_pkg::FRAC_W;
   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(wdw_pkg::MAX_ENTRIES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(wdw_pkg::MAX_ENTRIES);

   wdw_pkg::state_type  state_ff, state_in;
   wdw_pkg::status_type status_ff, status_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [W_BITS-1:0]   weight_ff, weight_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic                match_ff, match_in;
   logic                picked_ff, picked_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [TOTAL_W-1:0]  scaled_ff, scaled_in;
   logic [TOTAL_W-1:0]  prefix_ff, prefix_in;
   logic [ID_BITS-1:0]  got_ff, got_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [15:0]         rsp_drawn_id_ff, rsp_drawn_id_in;
   logic [6:0]          rsp_entry_count_ff, rsp_entry_count_in;

   logic                shift;
   wdw_pkg::entry_type  tail, head, next;

   logic                live, last, hit, match_now, pick_now;
   logic [W_BITS:0]     sat_sum;
   logic [TOTAL_W-1:0]  run_sum;
   logic [PROD_W-1:0]   product;

   wdw_chain u_chain (
      .clock (clock),
      .shift (shift),
      .tail  (tail),
      .head  (head),
      .next  (next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wdw_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff          <= status_in;
      step_ff            <= step_in;
      id_ff              <= id_in;
      weight_ff          <= weight_in;
      frac_ff            <= frac_in;
      match_ff           <= match_in;
      picked_ff          <= picked_in;
      total_ff           <= total_in;
      scaled_ff          <= scaled_in;
      prefix_ff          <= prefix_in;
      got_ff             <= got_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_drawn_id_ff    <= rsp_drawn_id_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

   assign live      = CNT_W'(step_ff) < count_ff;
   assign last      = step_ff == LAST_STEP;
   assign hit       = live && !match_ff && (head.id == id_ff);
   assign match_now = match_ff || hit;
   assign sat_sum   = {1'b0, head.weight} + {1'b0, weight_ff};
   assign run_sum   = prefix_ff + TOTAL_W'(head.weight);
   assign pick_now  = live && !picked_ff &&
                      ((run_sum > scaled_ff) || (CNT_W'(step_ff) == count_ff - CNT_W'(1)));
   assign product   = PROD_W'(total_ff) * PROD_W'(frac_ff);

   always_comb begin
      state_in           = state_ff;
      status_in          = status_ff;
      count_in           = count_ff;
      step_in            = step_ff;
      id_in              = id_ff;
      weight_in          = weight_ff;
      frac_in            = frac_ff;
      match_in           = match_ff;
      picked_in          = picked_ff;
      total_in           = total_ff;
      scaled_in          = scaled_ff;
      prefix_in          = prefix_ff;
      got_in             = got_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_drawn_id_in    = rsp_drawn_id_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      req_stall          = 1'b1;
      shift              = 1'b0;
      tail               = head;

      unique case (state_ff)
         wdw_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               id_in     = ID_BITS'(req_item_id);
               weight_in = req_weight;
               frac_in   = req_random_fraction;
               step_in   = '0;
               match_in  = 1'b0;
               picked_in = 1'b0;
               total_in  = '0;
               prefix_in = '0;
               got_in    = '0;
               status_in = wdw_pkg::ST_DONE;
               state_in  = wdw_pkg::S_RESP;
               unique case (req_operation)
                  wdw_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  wdw_pkg::OP_ADD: begin
                     if (req_weight == '0) begin
                        status_in = wdw_pkg::ST_ZERO;
                     end else begin
                        state_in = wdw_pkg::S_ADD_SCAN;
                     end
                  end
                  wdw_pkg::OP_DRAW: begin
                     state_in = wdw_pkg::S_SUM_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         wdw_pkg::S_ADD_SCAN: begin
            shift    = 1'b1;
            step_in  = step_ff + IDX_W'(1);
            match_in = match_now;
            if (hit) begin
               tail.weight = sat_sum[W_BITS] ? {W_BITS{1'b1}} : sat_sum[W_BITS-1:0];
            end else if (!match_ff && (CNT_W'(step_ff) == count_ff)) begin
               // first free slot passes after every live entry has been checked
               tail.id     = id_ff;
               tail.weight = weight_ff;
            end
            if (last) begin
               state_in = wdw_pkg::S_RESP;
               if (match_now) begin
                  status_in = wdw_pkg::ST_DONE;
               end else if (count_ff == FULL_CNT) begin
                  status_in = wdw_pkg::ST_FULL;
               end else begin
                  status_in = wdw_pkg::ST_DONE;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
         end

         wdw_pkg::S_SUM_SCAN: begin
            shift   = 1'b1;
            step_in = step_ff + IDX_W'(1);
            if (live) begin
               total_in = total_ff + TOTAL_W'(head.weight);
            end
            if (last) begin
               state_in = wdw_pkg::S_SCALE;
            end
         end

         wdw_pkg::S_SCALE: begin
            scaled_in = product[PROD_W-1:FRAC_W];
            if ((count_ff == '0) || (total_ff == '0)) begin
               status_in = wdw_pkg::ST_EMPTY;
               state_in  = wdw_pkg::S_RESP;
            end else begin
               state_in = wdw_pkg::S_PICK_SCAN;
            end
         end

         wdw_pkg::S_PICK_SCAN: begin
            shift     = 1'b1;
            step_in   = step_ff + IDX_W'(1);
            prefix_in = run_sum;
            if (pick_now) begin
               picked_in = 1'b1;
               got_in    = head.id;
            end
            // from the pick on, refill with the look-ahead entry to close the gap
            if (picked_ff || pick_now) begin
               tail = next;
            end
            if (last) begin
               status_in = wdw_pkg::ST_DRAWN;
               count_in  = count_ff - CNT_W'(1);
               state_in  = wdw_pkg::S_RESP;
            end
         end

         wdw_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = status_ff;
               rsp_drawn_id_in    = (status_ff == wdw_pkg::ST_DRAWN) ? 16'(got_ff) : 16'd0;
               rsp_entry_count_in = 7'(count_ff);
               state_in           = wdw_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = wdw_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_drawn_id    = rsp_drawn_id_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

/* bench/weighted_draw_without_replacement_test.sv */
// self-checking bench for weighted_draw_without_replacement: directed, full-table and random
// word streams with random stalls, checked against an in-bench candidate list predictor
// depends on wdw_pkg and the weighted_draw_without_replacement rtl
`timescale 1ns / 1ps

module weighted_draw_without_replacement_test;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 780;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      wdw_pkg::status_type status;
      logic [15:0] drawn_id;
      logic [6:0] entry_count;
   } draw_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = 2'd0;
   logic [15:0] req_item_id = 16'd0;
   logic [15:0] req_weight = 16'd0;
   logic [15:0] req_random_fraction = 16'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [15:0] rsp_drawn_id;
   logic [6:0] rsp_entry_count;

   // predictor copy of the candidate list
   logic [15:0] pool_ids [wdw_pkg::MAX_ENTRIES];
   logic [15:0] pool_weights [wdw_pkg::MAX_ENTRIES];
   int pool_size = 0;

   draw_outcome_type pending_outcomes [$];
   draw_outcome_type oldest_outcome;
   int mismatch_count = 0;
   int useful_words = 0;
   bit tx_gaps_on = 1'b1;
   bit rx_stalls_on = 1'b1;
   int hold_len = 0;
   int hold_left = 0;
   int stall_left = 0;

   weighted_draw_without_replacement DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_item_id(req_item_id),
      .req_weight(req_weight),
      .req_random_fraction(req_random_fraction),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_drawn_id(rsp_drawn_id),
      .rsp_entry_count(rsp_entry_count)
   );

   always #5 clock = ~clock;

   function automatic draw_outcome_type predict_word(logic [1:0] op, logic [15:0] id,
                                                     logic [15:0] w, logic [15:0] frac);
      draw_outcome_type res;
      logic [21:0] total;
      logic [21:0] prefix;
      logic [21:0] scaled;
      logic [37:0] product;
      logic [16:0] merged;
      int pick;
      bit found;
      res.status = wdw_pkg::ST_DONE;
      res.drawn_id = 16'd0;
      found = 1'b0;
      if (op == wdw_pkg::OP_CLEAR) begin
         pool_size = 0;
      end else if (op == wdw_pkg::OP_ADD) begin
         if (w == 16'd0) begin
            res.status = wdw_pkg::ST_ZERO;
         end else begin
            for (int i = 0; i < pool_size; i++) begin
               if (!found && pool_ids[i] == id) begin
                  merged = pool_weights[i] + w;
                  pool_weights[i] = merged[16] ? 16'hFFFF : merged[15:0];
                  found = 1'b1;
               end
            end
            if (!found) begin
               if (pool_size >= wdw_pkg::MAX_ENTRIES) begin
                  res.status = wdw_pkg::ST_FULL;
               end else begin
                  pool_ids[pool_size] = id;
                  pool_weights[pool_size] = w;
                  pool_size++;
               end
            end
         end
      end else if (op == wdw_pkg::OP_DRAW) begin
         total = '0;
         for (int i = 0; i < pool_size; i++)
            total += pool_weights[i];
         if (pool_size == 0 || total == '0) begin
            res.status = wdw_pkg::ST_EMPTY;
         end else begin
            product = total * frac;
            scaled = product[37:16];
            pick = pool_size - 1;
            prefix = '0;
            for (int i = 0; i < pool_size; i++) begin
               prefix += pool_weights[i];
               if (!found && prefix > scaled) begin
                  pick = i;
                  found = 1'b1;
               end
            end
            res.status = wdw_pkg::ST_DRAWN;
            res.drawn_id = pool_ids[pick];
            // close the gap, keeping order
            for (int i = pick; i + 1 < pool_size; i++) begin
               pool_ids[i] = pool_ids[i + 1];
               pool_weights[i] = pool_weights[i + 1];
            end
            pool_size--;
         end
      end
      res.entry_count = 7'(pool_size);
      return res;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!tx_gaps_on || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_weight();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 16'($urandom_range(1, 255));
      if (r < 85)
         return 16'($urandom_range(1, 65535));
      if (r < 96)
         return 16'hFFFF - 16'($urandom_range(0, 15));
      return 16'd0;
   endfunction

   function automatic logic [15:0] pick_fraction();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 16'd0;
      if (r < 20)
         return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   // offer one word and wait for it to be taken
   task automatic send_word(input logic [1:0] op, input logic [15:0] id,
                            input logic [15:0] w, input logic [15:0] frac);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_item_id <= id;
      req_weight <= w;
      req_random_fraction <= frac;
      do
         @(posedge clock);
      while (req_stall);
      pending_outcomes.push_back(predict_word(op, id, w, frac));
      if (op != OP_UNUSED && !(op == wdw_pkg::OP_ADD && w == 16'd0))
         useful_words++;
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic test_field_extremes();
      send_word(wdw_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, 16'h8000);
      send_word(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000);
      send_word(wdw_pkg::OP_ADD, 16'h0005, 16'h0000, 16'h0000);
      send_word(wdw_pkg::OP_ADD, 16'h0000, 16'h0001, 16'h0000);
      send_word(wdw_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // weight sum saturates
      send_word(wdw_pkg::OP_ADD, 16'hFFFF, 16'h0001, 16'h0000);
      send_word(wdw_pkg::OP_ADD, 16'h0000, 16'h8000, 16'h0000);
      send_word(wdw_pkg::OP_ADD, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_word(wdw_pkg::OP_ADD, 16'h5555, 16'hAAAA, 16'h5555);
      send_word(wdw_pkg::OP_DRAW, 16'h1234, 16'h0000, 16'h0000);
      send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, 16'hFFFF);
      send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, 16'h8000);
      send_word(wdw_pkg::OP_ADD, 16'h0001, 16'h0100, 16'h0000);
      send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, 16'h7FFF);
      send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, 16'h0001);
      send_word(wdw_pkg::OP_DRAW, 16'hFFFF, 16'hFFFF, 16'h4000);
      send_word(wdw_pkg::OP_ADD, 16'h7F7F, 16'h00FF, 16'h0000);
      send_word(wdw_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
      send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, 16'h0000);
   endtask

   task automatic test_full_table();
      send_word(wdw_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
      for (int i = 0; i < wdw_pkg::MAX_ENTRIES; i++)
         send_word(wdw_pkg::OP_ADD, 16'(i * 1031 + 7), pick_weight() | 16'd1, 16'h0000);
      send_word(wdw_pkg::OP_ADD, 16'hBEEF, 16'h0040, 16'h0000);
      // a known id still merges when there is no room
      send_word(wdw_pkg::OP_ADD, 16'(5 * 1031 + 7), 16'hFFFF, 16'h0000);
      send_word(wdw_pkg::OP_ADD, 16'hBEEF, 16'h0000, 16'h0000);
      send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, 16'h0000);
      send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, 16'hFFFF);
      send_word(wdw_pkg::OP_ADD, 16'hBEEF, 16'h0040, 16'h0000);
      send_word(wdw_pkg::OP_ADD, 16'hCAFE, 16'h0040, 16'h0000);
      send_word(wdw_pkg::OP_ADD, 16'hF00D, 16'h0040, 16'h0000);
      send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, 16'h8000);
   endtask

   task automatic test_random_sequences();
      int stop_at;
      int n_adds;
      int span;
      logic [15:0] base;
      stop_at = useful_words + RANDOM_WORDS;
      while (useful_words < stop_at) begin
         tx_gaps_on = ($urandom_range(0, 4) != 0);
         rx_stalls_on = ($urandom_range(0, 4) != 0);
         base = 16'($urandom);
         // narrow id spans give plenty of merges
         case ($urandom_range(0, 2))
            0: span = 4;
            1: span = 24;
            default: span = 65536;
         endcase
         if ($urandom_range(0, 3) == 0)
            send_word(wdw_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
         n_adds = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 72) : $urandom_range(1, 10);
         repeat (n_adds) begin
            if ($urandom_range(0, 19) == 0)
               send_word(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
            else if ($urandom_range(0, 4) == 0)
               send_word(wdw_pkg::OP_DRAW, 16'($urandom), 16'($urandom), pick_fraction());
            else
               send_word(wdw_pkg::OP_ADD, base + 16'($urandom_range(0, span - 1)),
                         pick_weight(), 16'($urandom));
         end
         repeat ($urandom_range(1, 10))
            send_word(wdw_pkg::OP_DRAW, 16'($urandom), 16'($urandom), pick_fraction());
      end
      tx_gaps_on = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_receiver_hold();
      tx_gaps_on = 1'b0;
      hold_len = 400;
      for (int i = 0; i < 16; i++) begin
         if (i % 3 == 2)
            send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, 16'($urandom));
         else
            send_word(wdw_pkg::OP_ADD, 16'($urandom_range(0, 7)), pick_weight(), 16'h0000);
      end
      tx_gaps_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      repeat (8)
         send_word(wdw_pkg::OP_ADD, 16'($urandom_range(0, 15)), pick_weight(), 16'h0000);
      idle_sender();
      wait (pending_outcomes.size() == 0);
      repeat (8)
         send_word(wdw_pkg::OP_DRAW, 16'h0000, 16'h0000, pick_fraction());
   endtask

   // receiver stall pattern, including the long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_len > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_len;
         hold_len = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
      end else if (!rx_stalls_on || $urandom_range(0, 1) == 0) begin
         rsp_stall <= 1'b0;
         stall_left = $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                    : $urandom_range(15, 60);
      end
   end

   // compare each taken result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("result word with nothing pending: status %0d", rsp_status);
            mismatch_count++;
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            if (rsp_status !== oldest_outcome.status) begin
               $error("status: expected %0d, got %0d", oldest_outcome.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_drawn_id !== oldest_outcome.drawn_id) begin
               $error("drawn_id: expected %h, got %h", oldest_outcome.drawn_id, rsp_drawn_id);
               mismatch_count++;
            end
            if (rsp_entry_count !== oldest_outcome.entry_count) begin
               $error("entry_count: expected %0d, got %0d", oldest_outcome.entry_count,
                      rsp_entry_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_full_table();
      test_receiver_hold();
      test_random_sequences();
      test_drain_pause();
      idle_sender();
      wait (pending_outcomes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
